// ===== design/mkn_pkg.sv =====
// Package for the message key normalizer: lexer mode codes, state and
// result types, key characters and byte class helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mkn_pkg;

  // Most key characters one message byte can produce
  localparam int MAX_RES = 6;
  localparam int RES_W   = $clog2(MAX_RES + 1);

  localparam logic [6:0] CH_DASH = 7'h2d;
  localparam logic [6:0] CH_P    = 7'h70;
  localparam logic [6:0] CH_N    = 7'h6e;
  localparam logic [6:0] CH_S    = 7'h73;
  localparam logic [6:0] CH_X    = 7'h78;

  typedef enum logic [3:0] {
    M_IDLE,
    M_ZERO,
    M_ZERO_X,
    M_HEX,
    M_MINUS,
    M_INT,
    M_DOT,
    M_FRAC,
    M_QUOTE
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  quote_dbl;
    logic  sep_pending;
  } lex_state_t;

  typedef logic [MAX_RES-1:0][6:0] res_chars_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

endpackage

`default_nettype wire

// ===== design/mkn_lexer.sv =====
// Combinational step of the key normalizer: one message byte against the
// lexer state gives the next state and up to six key characters.
// Depends on mkn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkn_lexer #(
  parameter int LEN_W = 8,
  parameter int CAP_W = 9
) (
  input  mkn_pkg::lex_state_t st,
  input  logic [LEN_W-1:0]    key_length,
  input  logic [CAP_W-1:0]    cap,
  input  logic [7:0]          msg_byte,
  input  logic                byte_valid,
  input  logic                end_of_message,
  output mkn_pkg::lex_state_t st_next,
  output logic [LEN_W-1:0]    key_length_next,
  output mkn_pkg::res_chars_t res_chars,
  output logic [mkn_pkg::RES_W-1:0] res_cnt,
  output logic                res_bare
);

  typedef struct packed {
    logic [LEN_W-1:0]            ln;
    logic                        sp;
    logic [mkn_pkg::RES_W-1:0]   n;
    mkn_pkg::res_chars_t         ch;
  } work_t;

  function automatic work_t emit(input work_t w, input logic [6:0] c);
    work_t o;
    o = w;
    if (o.n < mkn_pkg::RES_W'(mkn_pkg::MAX_RES)) begin
      o.ch[o.n] = c;
      o.n = o.n + 1'b1;
    end
    return o;
  endfunction

  function automatic work_t put_sep(input work_t w);
    work_t o;
    o = w;
    if (o.ln != '0) o.sp = 1'b1;
    return o;
  endfunction

  function automatic work_t put_alnum(input work_t w, input logic [7:0] c_in,
                                      input logic [CAP_W-1:0] cp);
    work_t          o;
    logic [7:0]     c;
    logic [CAP_W:0] l1;
    logic [CAP_W:0] l2;
    o  = w;
    c  = c_in;
    if ((c >= "A") && (c <= "Z")) c = c + 8'd32;
    l1 = (CAP_W + 1)'(w.ln) + 1'b1;
    l2 = (CAP_W + 1)'(w.ln) + 2'd2;
    if (w.sp) begin
      if (l2 <= {1'b0, cp}) begin
        o = emit(o, mkn_pkg::CH_DASH);
        o = emit(o, c[6:0]);
        o.ln = w.ln + LEN_W'(2);
        o.sp = 1'b0;
      end
    end else if (l1 <= {1'b0, cp}) begin
      o = emit(o, c[6:0]);
      o.ln = w.ln + LEN_W'(1);
    end
    return o;
  endfunction

  function automatic work_t put_token(input work_t w, input logic [6:0] t,
                                      input logic [CAP_W-1:0] cp);
    work_t o;
    o = put_sep(w);
    o = put_alnum(o, {1'b0, t}, cp);
    o = put_sep(o);
    return o;
  endfunction

  always_comb begin
    work_t           w;
    mkn_pkg::mode_t  md;
    logic            qd;
    logic            restart;
    logic [7:0]      b;

    w.ln    = key_length;
    w.sp    = st.sep_pending;
    w.n     = '0;
    w.ch    = '0;
    md      = st.mode;
    qd      = st.quote_dbl;
    b       = msg_byte;
    restart = 1'b0;
    res_bare = 1'b0;

    if (byte_valid) begin
      restart = 1'b1;
      case (md)
        mkn_pkg::M_ZERO: begin
          if ((b == "x") || (b == "X")) begin
            md = mkn_pkg::M_ZERO_X; restart = 1'b0;
          end else if (mkn_pkg::is_digit(b)) begin
            md = mkn_pkg::M_INT; restart = 1'b0;
          end else if (b == ".") begin
            md = mkn_pkg::M_DOT; restart = 1'b0;
          end else begin
            w = put_token(w, mkn_pkg::CH_N, cap);
          end
        end
        mkn_pkg::M_ZERO_X: begin
          if (mkn_pkg::is_hex(b)) begin
            md = mkn_pkg::M_HEX; restart = 1'b0;
          end else begin
            w = put_token(w, mkn_pkg::CH_N, cap);
            w = put_alnum(w, {1'b0, mkn_pkg::CH_X}, cap);
          end
        end
        mkn_pkg::M_HEX: begin
          if (mkn_pkg::is_hex(b)) restart = 1'b0;
          else w = put_token(w, mkn_pkg::CH_P, cap);
        end
        mkn_pkg::M_MINUS: begin
          if (mkn_pkg::is_digit(b)) begin
            md = mkn_pkg::M_INT; restart = 1'b0;
          end else begin
            w = put_sep(w);
          end
        end
        mkn_pkg::M_INT: begin
          if (mkn_pkg::is_digit(b)) begin
            restart = 1'b0;
          end else if (b == ".") begin
            md = mkn_pkg::M_DOT; restart = 1'b0;
          end else begin
            w = put_token(w, mkn_pkg::CH_N, cap);
          end
        end
        mkn_pkg::M_DOT: begin
          if (mkn_pkg::is_digit(b)) begin
            md = mkn_pkg::M_FRAC; restart = 1'b0;
          end else begin
            w = put_token(w, mkn_pkg::CH_N, cap);
            w = put_sep(w);
          end
        end
        mkn_pkg::M_FRAC: begin
          if (mkn_pkg::is_digit(b)) restart = 1'b0;
          else w = put_token(w, mkn_pkg::CH_N, cap);
        end
        mkn_pkg::M_QUOTE: begin
          restart = 1'b0;
          // close only on the quote kind that opened the string
          if (b == (qd ? 8'h22 : 8'h27)) begin
            w  = put_token(w, mkn_pkg::CH_S, cap);
            md = mkn_pkg::M_IDLE;
          end
        end
        default: begin
        end
      endcase

      if (restart) begin
        md = mkn_pkg::M_IDLE;
        if (b == "0") begin
          md = mkn_pkg::M_ZERO;
        end else if (mkn_pkg::is_digit(b)) begin
          md = mkn_pkg::M_INT;
        end else if (b == "-") begin
          md = mkn_pkg::M_MINUS;
        end else if ((b == 8'h27) || (b == 8'h22)) begin
          md = mkn_pkg::M_QUOTE;
          qd = (b == 8'h22);
        end else if (mkn_pkg::is_alnum(b)) begin
          w = put_alnum(w, b, cap);
        end else begin
          w = put_sep(w);
        end
      end
    end

    if (end_of_message) begin
      // flush the lookahead, then return to the idle state
      case (md)
        mkn_pkg::M_ZERO, mkn_pkg::M_INT, mkn_pkg::M_FRAC:
          w = put_token(w, mkn_pkg::CH_N, cap);
        mkn_pkg::M_ZERO_X: begin
          w = put_token(w, mkn_pkg::CH_N, cap);
          w = put_alnum(w, {1'b0, mkn_pkg::CH_X}, cap);
        end
        mkn_pkg::M_HEX:   w = put_token(w, mkn_pkg::CH_P, cap);
        mkn_pkg::M_MINUS: w = put_sep(w);
        mkn_pkg::M_DOT: begin
          w = put_token(w, mkn_pkg::CH_N, cap);
          w = put_sep(w);
        end
        mkn_pkg::M_QUOTE: w = put_token(w, mkn_pkg::CH_S, cap);
        default: begin
        end
      endcase
      if (w.n == '0) begin
        res_bare = 1'b1;
        w.n      = mkn_pkg::RES_W'(1);
      end
      md   = mkn_pkg::M_IDLE;
      qd   = 1'b0;
      w.ln = '0;
      w.sp = 1'b0;
    end

    st_next.mode        = md;
    st_next.quote_dbl   = qd;
    st_next.sep_pending = w.sp;
    key_length_next     = w.ln;
    res_chars           = w.ch;
    res_cnt             = w.n;
  end

endmodule

`default_nettype wire

// ===== design/message_key_normalizer.sv =====
// Top level of the message key normalizer: input register, lexer step,
// result buffer drained one key character per cycle while m_axis_tready is
// high. Depends on mkn_pkg and mkn_lexer.
//
//  channel   dir  tdata                 tuser        tlast
//  s_axis    in   msg_byte[7:0]         byte_valid   end_of_message
//  m_axis    out  key_char[6:0], pad 0  char_valid   key_done
//  cfg_wr    in   key_buffer_size[8:0]  -            -
//
// An item is held in the input register, lexed into the result buffer, and
// its key characters (0 to 6) leave it one per cycle while m_axis is ready.
// With m_axis ready, items giving at most one character flow at one per cycle;
// an item giving more holds the input until its last character leaves (port bound).
// Reset clears the lexer state and sets key_buffer_size to 256.
// A stalled output holds its transaction; the input stalls only once both
// the input register and the result buffer are occupied.
`timescale 1ns / 1ps
`default_nettype none

module message_key_normalizer #(
  parameter int KEY_BUFFER_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] msg_byte
  input  logic       s_axis_tlast,   // end_of_message
  input  logic       s_axis_tuser,   // byte_valid
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] key_char, [7] zero
  output logic       m_axis_tlast,   // key_done
  output logic       m_axis_tuser,   // char_valid
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data     // key_buffer_size
);

  localparam int LEN_W = (KEY_BUFFER_SIZE > 2) ? $clog2(KEY_BUFFER_SIZE) : 1;
  localparam int CAP_W = (LEN_W > 9) ? LEN_W : 9;
  localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(KEY_BUFFER_SIZE - 1);
  localparam int RES_W = mkn_pkg::RES_W;

  logic [8:0]           key_buffer_size;
  logic [CAP_W-1:0]     cap;
  logic [CAP_W-1:0]     cap_cfg;

  logic                 in_full;
  logic [7:0]           in_byte;
  logic                 in_valid;
  logic                 in_eom;

  mkn_pkg::lex_state_t  st;
  mkn_pkg::lex_state_t  st_next;
  logic [LEN_W-1:0]     key_length;
  logic [LEN_W-1:0]     key_length_next;

  mkn_pkg::res_chars_t  res_chars;
  logic [RES_W-1:0]     res_cnt;
  logic                 res_bare;

  mkn_pkg::res_chars_t  buf_chars;
  logic                 buf_bare;
  logic                 buf_eom;
  logic [RES_W-1:0]     buf_cnt;
  logic [RES_W-1:0]     buf_idx;

  logic                 out_fire;
  logic                 buf_free;
  logic                 take;

  assign cap_cfg = (key_buffer_size == 9'd0) ? '0 : CAP_W'(key_buffer_size - 9'd1);
  assign cap     = (cap_cfg > MAX_CAP) ? MAX_CAP : cap_cfg;

  mkn_lexer #(
    .LEN_W (LEN_W),
    .CAP_W (CAP_W)
  ) u_lexer (
    .st              (st),
    .key_length      (key_length),
    .cap             (cap),
    .msg_byte        (in_byte),
    .byte_valid      (in_valid),
    .end_of_message  (in_eom),
    .st_next         (st_next),
    .key_length_next (key_length_next),
    .res_chars       (res_chars),
    .res_cnt         (res_cnt),
    .res_bare        (res_bare)
  );

  assign m_axis_tvalid = (buf_idx != buf_cnt);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  // buffer is free now or after the transaction on its last character
  assign buf_free      = !m_axis_tvalid || (out_fire && ((buf_idx + 1'b1) == buf_cnt));
  assign take          = in_full && buf_free;
  assign s_axis_tready = !in_full || take;

  assign m_axis_tdata  = {1'b0, buf_bare ? 7'd0 : buf_chars[buf_idx]};
  assign m_axis_tuser  = !buf_bare;
  assign m_axis_tlast  = buf_eom && ((buf_idx + 1'b1) == buf_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_buffer_size <= 9'd256;
      in_full         <= 1'b0;
      st.mode         <= mkn_pkg::M_IDLE;
      st.quote_dbl    <= 1'b0;
      st.sep_pending  <= 1'b0;
      key_length      <= '0;
      buf_cnt         <= '0;
      buf_idx         <= '0;
    end else begin
      if (cfg_wr_en) key_buffer_size <= cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        in_full <= 1'b1;
      end else if (take) begin
        in_full <= 1'b0;
      end
      if (take) begin
        st         <= st_next;
        key_length <= key_length_next;
        buf_cnt    <= res_cnt;
        buf_idx    <= '0;
      end else if (out_fire) begin
        buf_idx <= buf_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_valid <= s_axis_tuser;
      in_eom   <= s_axis_tlast;
    end
    if (take) begin
      buf_chars <= res_chars;
      buf_bare  <= res_bare;
      buf_eom   <= in_eom;
    end
  end

endmodule

`default_nettype wire

// ===== design/mkn_checker.sv =====
// Port-level checks for the message key normalizer output stream, bound
// to the top level. Depends on message_key_normalizer.
`timescale 1ns / 1ps
`default_nettype none

module mkn_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // hold a stalled transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  // a bare end marker always closes the key
  a_bare_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("bare end marker without key_done");

  a_bare_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("bare end marker carries data");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind message_key_normalizer mkn_checker u_mkn_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
